// ===== rtl/go_back_n_sender_defines.svh =====
// ----------------------------------------------------------------------------
// go_back_n_sender_defines
// Assertion macros shared by the go-back-N sender modules.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_DEFINES_SVH
`define GO_BACK_N_SENDER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst is high
`define GBN_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared widths, codes, register defaults and types of the go-back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_W      = 32;  // sequence numbers, timer, packet count
  localparam int CNT_W      = 7;   // window counts, 0..WINDOW_MAX
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int WINDOW_MAX = 64;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_SIZE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 2'd2;

  // Register defaults
  localparam logic [CNT_W-1:0] WIN_SIZE_RST      = 7'd64;
  localparam logic [SEQ_W-1:0] TIMEOUT_TICKS_RST = 32'd1000;
  localparam logic [SEQ_W-1:0] TOTAL_PACKETS_RST = 32'd0;

  // Sequencer to output stage
  typedef struct packed {
    logic             push;    // new result into the hold register
    logic [SEQ_W-1:0] number;
    logic             resend;
    logic             done;
    logic             flush;   // request over: release the held result as last
  } emit_req_t;

  // Output stage to sequencer
  typedef struct packed {
    logic can_push;    // hold empty, or it can move on this cycle
    logic hold_valid;
  } emit_stat_t;

  // Window size with out-of-range values clamped to 1..WINDOW_MAX
  function automatic logic [CNT_W-1:0] eff_window(input logic [CNT_W-1:0] w);
    logic [CNT_W-1:0] r;
    if (w == '0) begin
      r = CNT_W'(1);
    end else if (w > CNT_W'(WINDOW_MAX)) begin
      r = CNT_W'(WINDOW_MAX);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

// ===== rtl/go_back_n_sender.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-back-N sender window control: start, ack and tick requests in, sequence
// numbers to transmit out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser = kind (start, ack, tick), tdata = ack
//   number. m_axis carries one result per send: tdata = sequence number,
//   tuser = {all_done, is_resend}, tlast on the final result of a request.
//   Registers (window size, timeout ticks, packet count) are written through
//   cfg_we / cfg_index / cfg_data while no request is in progress.
// Timing:
//   All 32-bit arithmetic goes through one shared add / subtract unit, one
//   operation per cycle. A new send steps through total compare, emit and
//   increment, a resend through emit and increment. An ack passes accept,
//   offset and base before its first send, a tick accept, count and compare;
//   after sends a request ends with the closing compare, end-of-request check
//   and flush, after resends with the end-of-request check and flush.
//   Each result sits in a hold register until the next result is formed or the
//   request ends, and then moves on to the output register, or later while the
//   receiver stalls.
// Reset: rst clears the window state, registers take their defaults.
// Stall: while m_axis is not taken, the sequencer waits at its next result;
//   s_axis_tready stays low until the request's last result has moved to the
//   output register.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_defines.svh"

module go_back_n_sender (
  input  logic                          clk,
  input  logic                          rst,
  // Requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gbn_pkg::SEQ_W-1:0]     s_axis_tdata,   // [31:0] ack_number
  input  logic [gbn_pkg::KIND_W-1:0]    s_axis_tuser,   // [1:0] kind
  // Sends
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [gbn_pkg::SEQ_W-1:0]     m_axis_tdata,   // [31:0] send_number
  output logic [1:0]                    m_axis_tuser,   // [0] is_resend, [1] all_done
  output logic                          m_axis_tlast,
  // Configuration
  input  logic                          cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbn_pkg::SEQ_W-1:0]     cfg_data
);

  gbn_pkg::emit_req_t  req;
  gbn_pkg::emit_stat_t stat;
  logic                m_resend;
  logic                m_done;

  gbn_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_ack    (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .stat      (stat)
  );

  gbn_out u_out (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .stat     (stat),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_number (m_axis_tdata),
    .m_resend (m_resend),
    .m_done   (m_done),
    .m_last   (m_axis_tlast)
  );

  assign m_axis_tuser = {m_done, m_resend};

  `GBN_ASSERT(a_idle_hold_empty, s_axis_tready, !stat.hold_valid, "ready with a result still held")
  `GBN_ASSERT_NEXT(a_accept_drops_ready, s_axis_tvalid && s_axis_tready && (s_axis_tuser == gbn_pkg::KIND_START), !s_axis_tready, "start did not begin a sequence")

endmodule

// ===== rtl/gbn_unit.sv =====
// ----------------------------------------------------------------------------
// gbn_unit
// Shared 32-bit add / subtract unit; borrow flags a < b on a subtract.
// ----------------------------------------------------------------------------
module gbn_unit (
  input  logic [gbn_pkg::SEQ_W-1:0] a,
  input  logic [gbn_pkg::SEQ_W-1:0] b,
  input  logic                      sub,
  output logic [gbn_pkg::SEQ_W-1:0] sum,
  output logic                      borrow
);

  logic [gbn_pkg::SEQ_W:0]   full;
  logic [gbn_pkg::SEQ_W-1:0] b_op;

  // a + b, or a + ~b + 1 for a - b
  assign b_op   = sub ? ~b : b;
  assign full   = {1'b0, a} + {1'b0, b_op} + {{gbn_pkg::SEQ_W{1'b0}}, sub};
  assign sum    = full[gbn_pkg::SEQ_W-1:0];
  assign borrow = sub & ~full[gbn_pkg::SEQ_W];

endmodule

// ===== rtl/gbn_seq.sv =====
// ----------------------------------------------------------------------------
// gbn_seq
// Window state, configuration registers and the sequencer around the shared
// add / subtract unit.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_defines.svh"

module gbn_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gbn_pkg::KIND_W-1:0]    in_kind,
  input  logic [gbn_pkg::SEQ_W-1:0]     in_ack,
  input  logic                          cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbn_pkg::SEQ_W-1:0]     cfg_data,
  output gbn_pkg::emit_req_t            req,
  input  gbn_pkg::emit_stat_t           stat
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ACK_SUB   = 4'd1;
  localparam logic [3:0] S_ACK_BASE  = 4'd2;
  localparam logic [3:0] S_FILL_CHK  = 4'd3;
  localparam logic [3:0] S_FILL_EMIT = 4'd4;
  localparam logic [3:0] S_FILL_INC  = 4'd5;
  localparam logic [3:0] S_DONE_CHK  = 4'd6;
  localparam logic [3:0] S_DONE_EMIT = 4'd7;
  localparam logic [3:0] S_TICK_INC  = 4'd8;
  localparam logic [3:0] S_TICK_CMP  = 4'd9;
  localparam logic [3:0] S_RESEND    = 4'd10;
  localparam logic [3:0] S_RES_INC   = 4'd11;
  localparam logic [3:0] S_FLUSH     = 4'd12;

  localparam int SW = gbn_pkg::SEQ_W;
  localparam int CW = gbn_pkg::CNT_W;

  logic [3:0]    state;
  logic [SW-1:0] window_base;
  logic [SW-1:0] next_number;
  logic [SW-1:0] timer_count;
  logic          running;
  logic [CW-1:0] outs;       // next_number - window_base, never above WINDOW_MAX
  logic [CW-1:0] sent;       // new sends of the current request
  logic [CW-1:0] res_idx;
  logic [SW-1:0] res_number;
  logic [SW-1:0] ack_reg;

  logic [CW-1:0] cfg_win_size;
  logic [SW-1:0] cfg_timeout_ticks;
  logic [SW-1:0] cfg_total_packets;

  logic [SW-1:0] u_a;
  logic [SW-1:0] u_b;
  logic          u_sub;
  logic [SW-1:0] u_sum;
  logic          u_borrow;

  logic [CW-1:0] win_eff;
  logic [SW-1:0] limit;
  logic          ack_in_win;
  logic          fill_ok;
  logic          res_more;

  gbn_unit u_unit (
    .a      (u_a),
    .b      (u_b),
    .sub    (u_sub),
    .sum    (u_sum),
    .borrow (u_borrow)
  );

  assign in_ready = (state == S_IDLE);
  assign win_eff  = gbn_pkg::eff_window(cfg_win_size);
  assign limit    = (cfg_timeout_ticks == '0) ? SW'(1) : cfg_timeout_ticks;

  // Ack offset from base lies inside the outstanding range
  assign ack_in_win = (u_sum[SW-1:CW] == '0) && (u_sum[CW-1:0] < outs);
  // next_number < total, window not full, result budget left
  assign fill_ok    = u_borrow && (outs < win_eff) && !sent[CW-1];
  assign res_more   = (res_idx < outs);

  // Operand select for the shared unit
  always_comb begin
    u_a   = '0;
    u_b   = '0;
    u_sub = 1'b0;
    case (state)
      S_ACK_SUB: begin
        u_a   = ack_reg;
        u_b   = window_base;
        u_sub = 1'b1;
      end
      S_ACK_BASE: begin
        u_a = ack_reg;
        u_b = SW'(1);
      end
      S_FILL_CHK: begin
        u_a   = next_number;
        u_b   = cfg_total_packets;
        u_sub = 1'b1;
      end
      S_FILL_INC: begin
        u_a = next_number;
        u_b = SW'(1);
      end
      S_DONE_CHK: begin
        u_a   = window_base;
        u_b   = cfg_total_packets;
        u_sub = 1'b1;
      end
      S_TICK_INC: begin
        u_a = timer_count;
        u_b = SW'(1);
      end
      S_TICK_CMP: begin
        u_a   = timer_count;
        u_b   = limit;
        u_sub = 1'b1;
      end
      S_RES_INC: begin
        u_a = res_number;
        u_b = SW'(1);
      end
      default: begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b0;
      end
    endcase
  end

  // Results toward the output stage
  always_comb begin
    req.push   = 1'b0;
    req.number = next_number;
    req.resend = 1'b0;
    req.done   = 1'b0;
    req.flush  = (state == S_FLUSH);
    case (state)
      S_FILL_EMIT: begin
        req.push = stat.can_push;
      end
      S_RESEND: begin
        req.push   = res_more && stat.can_push;
        req.number = res_number;
        req.resend = 1'b1;
      end
      S_DONE_EMIT: begin
        req.push   = stat.can_push;
        req.number = window_base;
        req.done   = 1'b1;
      end
      default: begin
        req.push = 1'b0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_win_size      <= gbn_pkg::WIN_SIZE_RST;
      cfg_timeout_ticks <= gbn_pkg::TIMEOUT_TICKS_RST;
      cfg_total_packets <= gbn_pkg::TOTAL_PACKETS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gbn_pkg::CFG_WIN_SIZE:      cfg_win_size      <= cfg_data[CW-1:0];
        gbn_pkg::CFG_TIMEOUT_TICKS: cfg_timeout_ticks <= cfg_data;
        gbn_pkg::CFG_TOTAL_PACKETS: cfg_total_packets <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ack number capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ack_reg <= in_ack;
    end
  end

  // Sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_base <= '0;
      next_number <= '0;
      timer_count <= '0;
      running     <= 1'b0;
      outs        <= '0;
      sent        <= '0;
      res_idx     <= '0;
      res_number  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sent <= '0;
            case (in_kind)
              gbn_pkg::KIND_START: begin
                window_base <= '0;
                next_number <= '0;
                timer_count <= '0;
                outs        <= '0;
                running     <= 1'b1;
                state       <= S_FILL_CHK;
              end
              gbn_pkg::KIND_ACK: begin
                if (running) begin
                  state <= S_ACK_SUB;
                end
              end
              gbn_pkg::KIND_TICK: begin
                if (!running || outs == '0) begin
                  timer_count <= '0;
                end else begin
                  state <= S_TICK_INC;
                end
              end
              default: ;
            endcase
          end
        end
        S_ACK_SUB: begin
          if (ack_in_win) begin
            outs        <= outs - u_sum[CW-1:0] - CW'(1);
            timer_count <= '0;
            state       <= S_ACK_BASE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ACK_BASE: begin
          window_base <= u_sum;
          state       <= S_FILL_CHK;
        end
        S_FILL_CHK: begin
          state <= fill_ok ? S_FILL_EMIT : S_DONE_CHK;
        end
        S_FILL_EMIT: begin
          if (stat.can_push) begin
            sent  <= sent + CW'(1);
            outs  <= outs + CW'(1);
            state <= S_FILL_INC;
          end
        end
        S_FILL_INC: begin
          next_number <= u_sum;
          state       <= S_FILL_CHK;
        end
        S_DONE_CHK: begin
          // base >= total while running: completion notice
          if (running && !u_borrow && !sent[CW-1]) begin
            state <= S_DONE_EMIT;
          end else begin
            state <= S_FLUSH;
          end
        end
        S_DONE_EMIT: begin
          if (stat.can_push) begin
            running     <= 1'b0;
            timer_count <= '0;
            state       <= S_FLUSH;
          end
        end
        S_TICK_INC: begin
          timer_count <= u_sum;
          state       <= S_TICK_CMP;
        end
        S_TICK_CMP: begin
          if (u_borrow) begin
            state <= S_IDLE;
          end else begin
            timer_count <= '0;
            res_number  <= window_base;
            res_idx     <= '0;
            state       <= S_RESEND;
          end
        end
        S_RESEND: begin
          if (!res_more) begin
            state <= S_FLUSH;
          end else if (stat.can_push) begin
            res_idx <= res_idx + CW'(1);
            state   <= S_RES_INC;
          end
        end
        S_RES_INC: begin
          res_number <= u_sum;
          state      <= S_RESEND;
        end
        S_FLUSH: begin
          if (stat.can_push) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GBN_ASSERT(a_outs_range, 1'b1, outs <= CW'(gbn_pkg::WINDOW_MAX), "outstanding count above window max")
  `GBN_ASSERT(a_resend_nonempty, state == S_RESEND, outs != '0, "resend with nothing outstanding")
  `GBN_ASSERT(a_push_allowed, req.push, stat.can_push, "result pushed while hold is blocked")
  `GBN_ASSERT_NEXT(a_done_clears, req.push && req.done, !running, "completion notice left transfer running")

endmodule

// ===== rtl/gbn_out.sv =====
// ----------------------------------------------------------------------------
// gbn_out
// Hold register plus output register: a result waits in hold until the next
// result or the end of the request tells whether it is the last one.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_defines.svh"

module gbn_out (
  input  logic                      clk,
  input  logic                      rst,
  input  gbn_pkg::emit_req_t        req,
  output gbn_pkg::emit_stat_t       stat,
  output logic                      m_valid,
  input  logic                      m_ready,
  output logic [gbn_pkg::SEQ_W-1:0] m_number,
  output logic                      m_resend,
  output logic                      m_done,
  output logic                      m_last
);

  logic                      hold_v;
  logic [gbn_pkg::SEQ_W-1:0] hold_number;
  logic                      hold_resend;
  logic                      hold_done;
  logic                      out_free;
  logic                      move;
  logic                      move_last;

  assign out_free        = !m_valid || m_ready;
  assign stat.can_push   = !hold_v || out_free;
  assign stat.hold_valid = hold_v;

  // Hold moves to the output on a new push, or as last on flush
  assign move      = hold_v && out_free && (req.push || req.flush);
  assign move_last = !req.push;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v  <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (move) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      if (req.push) begin
        hold_v <= 1'b1;
      end else if (move) begin
        hold_v <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (move) begin
      m_number <= hold_number;
      m_resend <= hold_resend;
      m_done   <= hold_done;
      m_last   <= move_last;
    end
    if (req.push) begin
      hold_number <= req.number;
      hold_resend <= req.resend;
      hold_done   <= req.done;
    end
  end

  `GBN_ASSERT_NEXT(a_push_moves_hold, req.push && hold_v, m_valid && !m_last, "held result not moved out")
  `GBN_ASSERT_NEXT(a_flush_last, req.flush && hold_v && out_free, m_valid && m_last && !hold_v, "flush did not release last result")
  `GBN_ASSERT(a_no_push_on_flush, req.flush, !req.push, "push during flush")

endmodule
